>>> src/hipt_pkg.sv
// Shared types, constants and helper functions for the HDMI island packet and timing detector.
`default_nettype none

package hipt_pkg;

    localparam int PACKET_WORDS = 32;
    localparam int COUNT_BITS = 24;
    localparam int LINE_BITS = 16;
    localparam int CAP_IDX_BITS = $clog2(PACKET_WORDS);
    localparam int DIV_CNT_BITS = $clog2(COUNT_BITS + 1);
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [4:0] PRE_RUN_MAX = 5'd31;
    localparam logic [CAP_IDX_BITS-1:0] CAP_LAST = CAP_IDX_BITS'(PACKET_WORDS - 1);

    localparam logic [7:0] PREAMBLE_BYTE0 = 8'h40;
    localparam logic [7:0] PREAMBLE_BYTE1 = 8'h01;
    localparam logic [7:0] PREAMBLE_BYTE2 = 8'h01;

    localparam logic [4:0] PREAMBLE_LEN_RESET = 5'd8;
    localparam logic [2:0] GUARD_WORDS_RESET = 3'd2;
    localparam logic [7:0] VIDEO_MARKER_RESET = 8'hc0;

    localparam logic [1:0] REG_PREAMBLE_LEN = 2'd0;
    localparam logic [1:0] REG_GUARD_WORDS = 2'd1;
    localparam logic [1:0] REG_VIDEO_MARKER = 2'd2;

    localparam logic KIND_PACKET = 1'b0;
    localparam logic KIND_TIMING = 1'b1;

    typedef enum logic [1:0] {
        CAP_SCAN   = 2'd0,
        CAP_GUARD  = 2'd1,
        CAP_PACKET = 2'd2
    } cap_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PKT,
        ST_PREP,
        ST_DIV_A,
        ST_DIV_B,
        ST_TIM
    } state_t;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic       frame_end;
    } word_in_t;

    typedef struct packed {
        logic                 kind;
        logic                 last_of_run;
        logic [31:0]          header_word;
        logic [31:0]          body_first;
        logic [31:0]          body_second;
        logic [LINE_BITS-1:0] line_total;
        logic [LINE_BITS-1:0] line_active;
        logic [LINE_BITS-1:0] frame_lines;
        logic [LINE_BITS-1:0] blank_lines;
        logic [LINE_BITS-1:0] active_lines;
        logic                 timing_valid;
    } result_t;

    typedef struct packed {
        logic                  start;
        logic [COUNT_BITS-1:0] dividend;
        logic [LINE_BITS-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [COUNT_BITS-1:0] quotient;
    } div_resp_t;

    function automatic logic [31:0] rev_each_byte(input logic [31:0] w);
        logic [31:0] r;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 8; j++) begin
                r[8*i + j] = w[8*i + 7 - j];
            end
        end
        return r;
    endfunction

    function automatic logic [LINE_BITS-1:0] sat_line(input logic [COUNT_BITS-1:0] v);
        logic [LINE_BITS-1:0] r;
        if (v > COUNT_BITS'(LINE_MAX)) begin
            r = LINE_MAX;
        end else begin
            r = v[LINE_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/hipt_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module hipt_divider (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire hipt_pkg::div_req_t req,
    output hipt_pkg::div_resp_t     resp
);
    import hipt_pkg::*;

    logic [LINE_BITS-1:0]    rem_reg, rem_next;
    logic [COUNT_BITS-1:0]   quo_reg, quo_next;
    logic [LINE_BITS-1:0]    div_reg, div_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [LINE_BITS:0]      shifted;
    logic                    fits;

    assign shifted = {rem_reg, quo_reg[COUNT_BITS-1]};
    assign fits = shifted >= {1'b0, div_reg};

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next = '0;
            quo_next = req.dividend;
            div_next = req.divisor;
            cnt_next = DIV_CNT_BITS'(COUNT_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = LINE_BITS'(shifted - {1'b0, div_reg});
            end else begin
                rem_next = shifted[LINE_BITS-1:0];
            end
            quo_next = {quo_reg[COUNT_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign resp.done = done_reg;
    assign resp.quotient = quo_reg;

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a running division");
`endif

endmodule

`default_nettype wire

>>> src/hdmi_island_packet_and_timing_detect.sv
// Top level: data island packet capture, video timing measurement and result sequencing.
// An item that causes no result leaves the block idle; ready is high again in the next cycle.
// A packet result appears in the output register in the cycle after its item is accepted.
// A frame end item with both runs complete does two divisions on the shared
// one-bit-per-cycle divider before its timing result appears; ready stays low until
// every result of the item is taken. Reset (aresetn, synchronous, active low) returns
// the registers to their reset values and capture state and run counters to zero.
`default_nettype none

module hdmi_island_packet_and_timing_detect (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire hipt_pkg::word_in_t                  s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output hipt_pkg::result_t                        m_data,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [hipt_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [hipt_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [hipt_pkg::APB_DATA_BITS-1:0]       prdata,
    output logic                                     pready
);
    import hipt_pkg::*;

    state_t state_reg, state_next;

    logic [4:0] preamble_len_reg;
    logic [2:0] guard_words_reg;
    logic [7:0] video_marker_reg;

    cap_phase_t              cap_phase_reg, cap_phase_next;
    logic [CAP_IDX_BITS-1:0] cap_index_reg, cap_index_next;
    logic [4:0]              pre_run_reg, pre_run_next;
    logic [31:0]             hdr_acc_reg, hdr_acc_next;
    logic [63:0]             body_acc_reg, body_acc_next;
    logic                    pkt_hit;

    logic                  in_active_reg, in_active_next;
    logic                  in_blank_reg, in_blank_next;
    logic [LINE_BITS-1:0]  active_run_reg, active_run_next;
    logic [LINE_BITS-1:0]  blank_run_reg, blank_run_next;
    logic [LINE_BITS-1:0]  saved_active_reg, saved_active_next;
    logic [LINE_BITS-1:0]  saved_blank_reg, saved_blank_next;
    logic [COUNT_BITS-1:0] word_count_reg, word_count_next;
    logic [COUNT_BITS-1:0] first_pos_reg, first_pos_next;
    logic                  seen_active_reg, seen_active_next;

    logic                  tim_pend_reg;
    logic                  tim_ok_reg;
    logic [LINE_BITS-1:0]  lt_reg;
    logic [LINE_BITS-1:0]  la_reg;
    logic [LINE_BITS-1:0]  fl_reg;
    logic [COUNT_BITS-1:0] wc_snap_reg;
    logic [COUNT_BITS-1:0] fap_snap_reg;
    result_t               out_reg;

    logic                 accept;
    logic                 cfg_write;
    logic                 is_preamble;
    logic                 is_marker;
    logic [CAP_IDX_BITS-1:0] guard_idx;
    logic [4:0]           pre_run_inc;
    logic [LINE_BITS:0]   lt_sum;
    logic [LINE_BITS-1:0] lt_sat;
    logic                 tim_ok_now;
    logic [LINE_BITS-1:0] bl_sat;
    result_t              pkt_res;
    result_t              tim_res;
    logic                 load_tim;
    div_req_t             div_req;
    div_resp_t            div_resp;

    assign accept = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    assign is_preamble = (s_data.byte0 == PREAMBLE_BYTE0) && (s_data.byte1 == PREAMBLE_BYTE1)
                         && (s_data.byte2 == PREAMBLE_BYTE2);
    assign is_marker = s_data.byte0 == video_marker_reg;
    assign guard_idx = cap_index_reg + 1'b1;
    assign pre_run_inc = (pre_run_reg < PRE_RUN_MAX) ? pre_run_reg + 1'b1 : pre_run_reg;

    always_comb begin
        cap_phase_next = cap_phase_reg;
        cap_index_next = cap_index_reg;
        pre_run_next = pre_run_reg;
        hdr_acc_next = hdr_acc_reg;
        body_acc_next = body_acc_reg;
        pkt_hit = 1'b0;
        case (cap_phase_reg)
            CAP_GUARD: begin
                if (guard_idx >= CAP_IDX_BITS'(guard_words_reg)) begin
                    cap_phase_next = CAP_PACKET;
                    cap_index_next = '0;
                    hdr_acc_next = '0;
                    body_acc_next = '0;
                end else begin
                    cap_index_next = guard_idx;
                end
            end
            CAP_PACKET: begin
                hdr_acc_next[~cap_index_reg] = hdr_acc_reg[~cap_index_reg] | s_data.byte3[2];
                body_acc_next[{cap_index_reg[4], ~cap_index_reg[3:0], 1'b1}] =
                    body_acc_reg[{cap_index_reg[4], ~cap_index_reg[3:0], 1'b1}] | s_data.byte2[0];
                body_acc_next[{cap_index_reg[4], ~cap_index_reg[3:0], 1'b0}] =
                    body_acc_reg[{cap_index_reg[4], ~cap_index_reg[3:0], 1'b0}] | s_data.byte1[0];
                if (cap_index_reg == CAP_LAST) begin
                    pkt_hit = 1'b1;
                    cap_phase_next = CAP_SCAN;
                    cap_index_next = '0;
                    pre_run_next = '0;
                end else begin
                    cap_index_next = cap_index_reg + 1'b1;
                end
            end
            default: begin
                cap_phase_next = CAP_SCAN;
                if (is_preamble) begin
                    if (pre_run_inc >= preamble_len_reg) begin
                        pre_run_next = '0;
                        cap_index_next = '0;
                        if (guard_words_reg == 3'd0) begin
                            cap_phase_next = CAP_PACKET;
                            hdr_acc_next = '0;
                            body_acc_next = '0;
                        end else begin
                            cap_phase_next = CAP_GUARD;
                        end
                    end else begin
                        pre_run_next = pre_run_inc;
                    end
                end else begin
                    pre_run_next = '0;
                end
            end
        endcase
    end

    always_comb begin
        in_active_next = in_active_reg;
        in_blank_next = in_blank_reg;
        active_run_next = active_run_reg;
        blank_run_next = blank_run_reg;
        saved_active_next = saved_active_reg;
        saved_blank_next = saved_blank_reg;
        first_pos_next = first_pos_reg;
        seen_active_next = seen_active_reg;
        word_count_next = (word_count_reg < COUNT_MAX) ? word_count_reg + 1'b1 : word_count_reg;
        if (is_marker) begin
            if (!seen_active_reg) begin
                first_pos_next = word_count_next;
                seen_active_next = 1'b1;
            end
            in_active_next = 1'b1;
            if (active_run_reg < LINE_MAX) begin
                active_run_next = active_run_reg + 1'b1;
            end
            if (in_blank_reg) begin
                in_blank_next = 1'b0;
                saved_blank_next = blank_run_reg;
                blank_run_next = '0;
            end
        end else begin
            if (in_active_reg) begin
                saved_active_next = active_run_reg;
                in_active_next = 1'b0;
                in_blank_next = 1'b1;
            end
            if (in_blank_next && blank_run_reg < LINE_MAX) begin
                blank_run_next = blank_run_reg + 1'b1;
            end
            active_run_next = '0;
        end
    end

    assign lt_sum = {1'b0, saved_active_next} + {1'b0, saved_blank_next};
    assign lt_sat = lt_sum[LINE_BITS] ? LINE_MAX : lt_sum[LINE_BITS-1:0];
    assign tim_ok_now = (saved_active_next != '0) && (saved_blank_next != '0) && seen_active_next;

    always_comb begin
        pkt_res = '0;
        pkt_res.kind = KIND_PACKET;
        pkt_res.last_of_run = !s_data.frame_end;
        pkt_res.header_word = rev_each_byte(hdr_acc_next);
        pkt_res.body_first = rev_each_byte(body_acc_next[31:0]);
        pkt_res.body_second = rev_each_byte(body_acc_next[63:32]);
    end

    assign bl_sat = sat_line(div_resp.quotient);

    always_comb begin
        tim_res = '0;
        tim_res.kind = KIND_TIMING;
        tim_res.last_of_run = 1'b1;
        if (tim_ok_reg) begin
            tim_res.line_total = lt_reg;
            tim_res.line_active = la_reg;
            tim_res.frame_lines = fl_reg;
            tim_res.blank_lines = bl_sat;
            tim_res.active_lines = (fl_reg > bl_sat) ? fl_reg - bl_sat : '0;
            tim_res.timing_valid = 1'b1;
        end
    end

    assign load_tim = (state_reg == ST_PREP && !tim_ok_reg) || (state_reg == ST_DIV_B && div_resp.done);

    always_comb begin
        div_req.start = (state_reg == ST_PREP && tim_ok_reg) || (state_reg == ST_DIV_A && div_resp.done);
        div_req.dividend = (state_reg == ST_PREP) ? wc_snap_reg : fap_snap_reg;
        div_req.divisor = lt_reg;
    end

    hipt_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .resp    (div_resp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (pkt_hit) begin
                        state_next = ST_PKT;
                    end else if (s_data.frame_end) begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PKT: begin
                if (m_ready) begin
                    state_next = tim_pend_reg ? ST_PREP : ST_IDLE;
                end
            end
            ST_PREP: begin
                state_next = tim_ok_reg ? ST_DIV_A : ST_TIM;
            end
            ST_DIV_A: begin
                if (div_resp.done) begin
                    state_next = ST_DIV_B;
                end
            end
            ST_DIV_B: begin
                if (div_resp.done) begin
                    state_next = ST_TIM;
                end
            end
            ST_TIM: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_PKT:  m_valid = 1'b1;
            ST_TIM:  m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    assign m_data = out_reg;

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            REG_PREAMBLE_LEN: prdata = APB_DATA_BITS'(preamble_len_reg);
            REG_GUARD_WORDS:  prdata = APB_DATA_BITS'(guard_words_reg);
            REG_VIDEO_MARKER: prdata = APB_DATA_BITS'(video_marker_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            preamble_len_reg <= PREAMBLE_LEN_RESET;
            guard_words_reg <= GUARD_WORDS_RESET;
            video_marker_reg <= VIDEO_MARKER_RESET;
            cap_phase_reg <= CAP_SCAN;
            cap_index_reg <= '0;
            pre_run_reg <= '0;
            hdr_acc_reg <= '0;
            body_acc_reg <= '0;
            in_active_reg <= 1'b0;
            in_blank_reg <= 1'b0;
            active_run_reg <= '0;
            blank_run_reg <= '0;
            saved_active_reg <= '0;
            saved_blank_reg <= '0;
            word_count_reg <= '0;
            first_pos_reg <= '0;
            seen_active_reg <= 1'b0;
            tim_pend_reg <= 1'b0;
            tim_ok_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_write) begin
                case (paddr[3:2])
                    REG_PREAMBLE_LEN: preamble_len_reg <= pwdata[4:0];
                    REG_GUARD_WORDS:  guard_words_reg <= pwdata[2:0];
                    REG_VIDEO_MARKER: video_marker_reg <= pwdata[7:0];
                    default: begin
                        preamble_len_reg <= preamble_len_reg;
                    end
                endcase
            end
            if (accept) begin
                cap_phase_reg <= cap_phase_next;
                cap_index_reg <= cap_index_next;
                pre_run_reg <= pre_run_next;
                hdr_acc_reg <= hdr_acc_next;
                body_acc_reg <= body_acc_next;
                tim_pend_reg <= s_data.frame_end;
                tim_ok_reg <= tim_ok_now;
                if (s_data.frame_end) begin
                    in_active_reg <= 1'b0;
                    in_blank_reg <= 1'b0;
                    active_run_reg <= '0;
                    blank_run_reg <= '0;
                    saved_active_reg <= '0;
                    saved_blank_reg <= '0;
                    word_count_reg <= '0;
                    first_pos_reg <= '0;
                    seen_active_reg <= 1'b0;
                end else begin
                    in_active_reg <= in_active_next;
                    in_blank_reg <= in_blank_next;
                    active_run_reg <= active_run_next;
                    blank_run_reg <= blank_run_next;
                    saved_active_reg <= saved_active_next;
                    saved_blank_reg <= saved_blank_next;
                    word_count_reg <= word_count_next;
                    first_pos_reg <= first_pos_next;
                    seen_active_reg <= seen_active_next;
                end
            end
        end
        if (accept) begin
            lt_reg <= lt_sat;
            la_reg <= saved_active_next;
            wc_snap_reg <= word_count_next;
            fap_snap_reg <= first_pos_next;
        end
        if (state_reg == ST_DIV_A && div_resp.done) begin
            fl_reg <= bl_sat;
        end
        if (accept && pkt_hit) begin
            out_reg <= pkt_res;
        end else if (load_tim) begin
            out_reg <= tim_res;
        end
    end

`ifndef SYNTH
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result item is pending");

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_resp.done |-> (state_reg == ST_DIV_A) || (state_reg == ST_DIV_B))
        else $error("division finished outside a wait state");

    a_pkt_back_to_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PKT) |-> (cap_phase_reg == CAP_SCAN))
        else $error("packet item emitted while capture still running");

    a_timing_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_TIMING && m_data.timing_valid)
        |-> (m_data.blank_lines <= m_data.frame_lines)
            && (m_data.line_active <= m_data.line_total))
        else $error("timing item fields out of order");

    a_pkt_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PKT) |-> (m_data.last_of_run == !tim_pend_reg))
        else $error("packet item last flag disagrees with pending timing item");
`endif

endmodule

`default_nettype wire

>>> dv/island_timing_check.sv
// Checker for the HDMI island packet and timing detector: predicts every result and compares.
`timescale 1ns / 100ps

module island_timing_check (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    input  wire logic                               s_ready,
    input  wire hipt_pkg::word_in_t                 s_data,
    input  wire logic                               m_valid,
    input  wire logic                               m_ready,
    input  wire hipt_pkg::result_t                  m_data,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic                               pready,
    input  wire logic [hipt_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [hipt_pkg::APB_DATA_BITS-1:0] pwdata,
    output int                                      fail_count,
    output int                                      pending
);
    import hipt_pkg::*;

    logic [4:0]            cfg_pre_len;
    logic [2:0]            cfg_guard;
    logic [7:0]            cfg_marker;

    logic [4:0]            pre_count;
    cap_phase_t            phase;
    logic [4:0]            cap_idx;
    logic [31:0]           hdr_bits;
    logic [63:0]           body_bits;

    bit                    act_on;
    bit                    blank_on;
    bit                    act_seen;
    logic [LINE_BITS-1:0]  act_len;
    logic [LINE_BITS-1:0]  blank_len;
    logic [LINE_BITS-1:0]  last_act;
    logic [LINE_BITS-1:0]  last_blank;
    logic [COUNT_BITS-1:0] words_seen;
    logic [COUNT_BITS-1:0] first_act_at;

    result_t               reports_due[$];

    initial begin
        fail_count = 0;
        pending = 0;
    end

    function automatic logic [31:0] flip_bytes(input logic [31:0] w);
        logic [31:0] r;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 8; j++) begin
                r[8*i + j] = w[8*i + 7 - j];
            end
        end
        return r;
    endfunction

    task automatic clear_timing();
        act_on = 0;
        blank_on = 0;
        act_seen = 0;
        act_len = '0;
        blank_len = '0;
        last_act = '0;
        last_blank = '0;
        words_seen = '0;
        first_act_at = '0;
    endtask

    task automatic open_packet();
        phase = CAP_PACKET;
        cap_idx = '0;
        hdr_bits = '0;
        body_bits = '0;
    endtask

    task automatic advance_island_and_timing(input word_in_t w);
        result_t     pkt;
        result_t     tim;
        bit          has_pkt;
        int          k;
        int          base;
        int unsigned line_len;
        int unsigned lines_all;
        int unsigned lines_blank;
        has_pkt = 0;
        pkt = '0;
        tim = '0;
        case (phase)
            CAP_GUARD: begin
                cap_idx = cap_idx + 5'd1;
                if (cap_idx >= 5'(cfg_guard)) begin
                    open_packet();
                end
            end
            CAP_PACKET: begin
                k = int'(cap_idx[3:0]);
                base = cap_idx[4] ? 32 : 0;
                hdr_bits[31 - int'(cap_idx)] = w.byte3[2];
                body_bits[base + 31 - 2*k] = w.byte2[0];
                body_bits[base + 30 - 2*k] = w.byte1[0];
                if (cap_idx == CAP_LAST) begin
                    pkt.kind = KIND_PACKET;
                    pkt.header_word = flip_bytes(hdr_bits);
                    pkt.body_first = flip_bytes(body_bits[31:0]);
                    pkt.body_second = flip_bytes(body_bits[63:32]);
                    has_pkt = 1;
                    phase = CAP_SCAN;
                    cap_idx = '0;
                    pre_count = '0;
                end else begin
                    cap_idx = cap_idx + 5'd1;
                end
            end
            default: begin
                phase = CAP_SCAN;
                if (w.byte0 == PREAMBLE_BYTE0 && w.byte1 == PREAMBLE_BYTE1 &&
                    w.byte2 == PREAMBLE_BYTE2) begin
                    if (pre_count < PRE_RUN_MAX) begin
                        pre_count = pre_count + 5'd1;
                    end
                    if (pre_count >= cfg_pre_len) begin
                        pre_count = '0;
                        if (cfg_guard == 3'd0) begin
                            open_packet();
                        end else begin
                            phase = CAP_GUARD;
                            cap_idx = '0;
                        end
                    end
                end else begin
                    pre_count = '0;
                end
            end
        endcase

        if (words_seen < COUNT_MAX) begin
            words_seen = words_seen + 1'b1;
        end
        if (w.byte0 == cfg_marker) begin
            if (!act_seen) begin
                first_act_at = words_seen;
                act_seen = 1;
            end
            act_on = 1;
            if (act_len < LINE_MAX) begin
                act_len = act_len + 1'b1;
            end
            if (blank_on) begin
                blank_on = 0;
                last_blank = blank_len;
                blank_len = '0;
            end
        end else begin
            if (act_on) begin
                last_act = act_len;
                act_on = 0;
                blank_on = 1;
            end
            if (blank_on && blank_len < LINE_MAX) begin
                blank_len = blank_len + 1'b1;
            end
            act_len = '0;
        end

        if (w.frame_end) begin
            tim.kind = KIND_TIMING;
            if (last_act != 0 && last_blank != 0 && act_seen) begin
                line_len = int'(last_act) + int'(last_blank);
                if (line_len > LINE_MAX) begin
                    line_len = LINE_MAX;
                end
                lines_all = int'(words_seen) / line_len;
                if (lines_all > LINE_MAX) begin
                    lines_all = LINE_MAX;
                end
                lines_blank = int'(first_act_at) / line_len;
                if (lines_blank > LINE_MAX) begin
                    lines_blank = LINE_MAX;
                end
                tim.line_total = LINE_BITS'(line_len);
                tim.line_active = last_act;
                tim.frame_lines = LINE_BITS'(lines_all);
                tim.blank_lines = LINE_BITS'(lines_blank);
                tim.active_lines = (lines_all > lines_blank) ?
                                   LINE_BITS'(lines_all - lines_blank) : '0;
                tim.timing_valid = 1'b1;
            end
            clear_timing();
        end

        if (has_pkt) begin
            pkt.last_of_run = !w.frame_end;
            reports_due.push_back(pkt);
        end
        if (w.frame_end) begin
            tim.last_of_run = 1'b1;
            reports_due.push_back(tim);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            cfg_pre_len = PREAMBLE_LEN_RESET;
            cfg_guard = GUARD_WORDS_RESET;
            cfg_marker = VIDEO_MARKER_RESET;
            pre_count = '0;
            phase = CAP_SCAN;
            cap_idx = '0;
            hdr_bits = '0;
            body_bits = '0;
            clear_timing();
            reports_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_PREAMBLE_LEN: cfg_pre_len = pwdata[4:0];
                    REG_GUARD_WORDS:  cfg_guard = pwdata[2:0];
                    REG_VIDEO_MARKER: cfg_marker = pwdata[7:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                advance_island_and_timing(s_data);
            end
            if (m_valid && m_ready) begin
                if (reports_due.size() == 0) begin
                    $error("result item arrived with no result expected");
                    fail_count++;
                end else begin
                    want = reports_due.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(m_data.kind));
                    compare_field("last_of_run", 32'(want.last_of_run),
                                  32'(m_data.last_of_run));
                    compare_field("header_word", want.header_word, m_data.header_word);
                    compare_field("body_first", want.body_first, m_data.body_first);
                    compare_field("body_second", want.body_second, m_data.body_second);
                    compare_field("line_total", 32'(want.line_total),
                                  32'(m_data.line_total));
                    compare_field("line_active", 32'(want.line_active),
                                  32'(m_data.line_active));
                    compare_field("frame_lines", 32'(want.frame_lines),
                                  32'(m_data.frame_lines));
                    compare_field("blank_lines", 32'(want.blank_lines),
                                  32'(m_data.blank_lines));
                    compare_field("active_lines", 32'(want.active_lines),
                                  32'(m_data.active_lines));
                    compare_field("timing_valid", 32'(want.timing_valid),
                                  32'(m_data.timing_valid));
                end
            end
        end
        pending = reports_due.size();
    end

endmodule

>>> dv/tb.sv
// Testbench top for the HDMI island packet and timing detector: clock, reset, stimulus, verdict.
`timescale 1ns / 100ps

module tb;
    import hipt_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE_CYCLES = 60;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int WORDS_PER_PHASE = 330;

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    word_in_t                 s_data = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    result_t                  m_data;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int                       fail_count;
    int                       pending;
    int                       words_taken = 0;
    int                       send_idle_pct = 0;
    int                       recv_stall_pct = 0;
    bit                       rx_hold_req = 0;
    int                       cycles = 0;

    logic [4:0]               cur_pre_len = PREAMBLE_LEN_RESET;
    logic [2:0]               cur_guard = GUARD_WORDS_RESET;
    logic [7:0]               cur_marker = VIDEO_MARKER_RESET;

    hdmi_island_packet_and_timing_detect DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    island_timing_check check_u (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 0;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic word_in_t any_word(input bit fe);
        word_in_t w;
        w.byte0 = 8'($urandom_range(255));
        w.byte1 = 8'($urandom_range(255));
        w.byte2 = 8'($urandom_range(255));
        w.byte3 = 8'($urandom_range(255));
        w.frame_end = fe;
        return w;
    endfunction

    function automatic word_in_t noise_word(input bit fe);
        word_in_t w;
        w = any_word(fe);
        while (w.byte0 == cur_marker) begin
            w.byte0 = 8'($urandom_range(255));
        end
        return w;
    endfunction

    function automatic word_in_t marker_word(input bit fe);
        word_in_t w;
        w = any_word(fe);
        w.byte0 = cur_marker;
        return w;
    endfunction

    function automatic word_in_t preamble_word();
        word_in_t w;
        w = any_word(1'b0);
        w.byte0 = PREAMBLE_BYTE0;
        w.byte1 = PREAMBLE_BYTE1;
        w.byte2 = PREAMBLE_BYTE2;
        return w;
    endfunction

    task automatic send_word(input word_in_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        words_taken++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic [4:0] pre_len, input logic [2:0] guard,
                              input logic [7:0] marker);
        drain();
        write_reg(REG_PREAMBLE_LEN, 32'(pre_len));
        write_reg(REG_GUARD_WORDS, 32'(guard));
        write_reg(REG_VIDEO_MARKER, 32'(marker));
        cur_pre_len = pre_len;
        cur_guard = guard;
        cur_marker = marker;
    endtask

    task automatic send_island(input bit fe_last);
        word_in_t w;
        int       run;
        int       i;
        run = (cur_pre_len == 0) ? 1 : int'(cur_pre_len);
        if ($urandom_range(99) < 15) begin
            // A preamble that breaks off before it is long enough.
            for (i = 0; i < $urandom_range(run - 1); i++) begin
                send_word(preamble_word());
            end
            send_word(noise_word(fe_last));
        end else begin
            for (i = 0; i < run; i++) begin
                send_word(preamble_word());
            end
            for (i = 0; i < int'(cur_guard); i++) begin
                send_word(any_word(1'b0));
            end
            for (i = 0; i < PACKET_WORDS; i++) begin
                w = any_word(1'b0);
                w.frame_end = (i == PACKET_WORDS - 1) ? fe_last : 1'b0;
                send_word(w);
            end
        end
    endtask

    task automatic send_frame();
        int lines;
        int i;
        int j;
        lines = $urandom_range(1, 4);
        for (i = 0; i < lines; i++) begin
            if ($urandom_range(19) == 0) begin
                send_word(any_word(1'($urandom_range(1))));
            end
            for (j = 0; j < $urandom_range(1, 6); j++) begin
                send_word(noise_word(1'b0));
            end
            if ($urandom_range(99) < 35) begin
                send_island(1'b0);
            end
            for (j = 0; j < $urandom_range(1, 8); j++) begin
                send_word(marker_word(1'b0));
            end
        end
        case ($urandom_range(9))
            0, 1: send_island(1'b1);
            2: send_word(marker_word(1'b1));
            default: send_word(noise_word(1'b1));
        endcase
    endtask

    initial begin : stimulus
        word_in_t w;
        int       p;
        int       frames;
        int       stop_at;
        int       i;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Field extremes, then a frame end with no active video at all.
        send_word('{8'h00, 8'h00, 8'h00, 8'h00, 1'b0});
        send_word('{8'hff, 8'hff, 8'hff, 8'hff, 1'b0});
        send_word('{8'hff, 8'hff, 8'hff, 8'hff, 1'b1});
        // A short frame with complete active and blank runs.
        send_word(marker_word(1'b0));
        send_word(marker_word(1'b0));
        send_word(noise_word(1'b0));
        send_word(noise_word(1'b0));
        send_word(marker_word(1'b1));
        // Active video with no blank run after it.
        send_word(marker_word(1'b0));
        send_word(marker_word(1'b1));

        // Zero preamble length and zero guard words; the last packet word also ends the frame.
        set_config(5'd0, 3'd0, VIDEO_MARKER_RESET);
        send_word(preamble_word());
        for (i = 0; i < PACKET_WORDS; i++) begin
            w = (i % 2 == 0) ? word_in_t'{8'hff, 8'hff, 8'hff, 8'hff, 1'b0} :
                               word_in_t'{8'h00, 8'h00, 8'h00, 8'h00, 1'b0};
            w.frame_end = (i == PACKET_WORDS - 1);
            send_word(w);
        end

        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    set_config(5'd31, 3'd7, 8'h00);
                end
                1: begin
                    send_idle_pct = 77;
                    recv_stall_pct = 0;
                    set_config(5'd1, 3'd0, 8'hff);
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 77;
                    set_config(5'($urandom_range(31)), 3'($urandom_range(7)),
                               8'($urandom_range(255)));
                end
                default: begin
                    send_idle_pct = 31;
                    recv_stall_pct = 31;
                    set_config(5'($urandom_range(1, 31)), 3'($urandom_range(7)), 8'h40);
                end
            endcase
            stop_at = words_taken + WORDS_PER_PHASE;
            frames = 0;
            while (words_taken < stop_at) begin
                send_frame();
                frames++;
                if (p == 0 && frames == 3) begin
                    rx_hold_req = 1;
                end
                if (p == 1 && frames == 4) begin
                    drain();
                end
                if (p >= 2 && frames % 5 == 0) begin
                    set_config(5'($urandom_range(31)), 3'($urandom_range(7)),
                               8'($urandom_range(255)));
                end
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
